@@ rtl/pcm_pkg.sv @@
package pcm_pkg;

  localparam int unsigned NumLanes    = 3;
  localparam int unsigned DivSteps    = 4;
  localparam int unsigned BitsPerStep = 2;

  localparam int unsigned LaneRed   = 0;
  localparam int unsigned LaneGreen = 1;
  localparam int unsigned LaneBlue  = 2;

  localparam logic [7:0] Full           = 8'd255;
  localparam logic [8:0] FullDiv        = 9'd255;
  localparam logic [8:0] Levels         = 9'd256;
  localparam logic [7:0] JetRedOffset   = 8'd96;
  localparam logic [7:0] JetGreenOffset = 8'd32;
  localparam logic [7:0] JetBlueOffset  = 8'd224;
  localparam logic [7:0] JetRedFloor    = 8'd64;
  localparam logic [7:0] JetBlueCeil    = 8'd192;
  localparam logic [7:0] JetRise        = 8'd63;
  localparam logic [7:0] JetHoldEnd     = 8'd128;
  localparam logic [7:0] JetFallEnd     = 8'd191;
  localparam logic [7:0] JetFallBase    = 8'd127;

  typedef enum logic [1:0] {
    MODE_CONST = 2'd0,
    MODE_TEMP  = 2'd1,
    MODE_JET   = 2'd2
  } pcm_mode_e;

  typedef enum logic [2:0] {
    REG_MAP_MODE   = 3'd0,
    REG_TINT_RED   = 3'd1,
    REG_TINT_GREEN = 3'd2,
    REG_TINT_BLUE  = 3'd3,
    REG_RED_SPAN   = 3'd4,
    REG_GREEN_SPAN = 3'd5
  } pcm_reg_e;

  typedef struct packed {
    logic [15:0] rem;
    logic [8:0]  dvs;
    logic [7:0]  quo;
  } pcm_lane_t;

  typedef pcm_lane_t [NumLanes-1:0] pcm_lanes_t;

  function automatic pcm_lane_t lane_const(logic [7:0] value);
    pcm_lane_t l;
    l.rem = 16'd0;
    l.dvs = 9'd1;
    l.quo = value;
    return l;
  endfunction

  function automatic pcm_lane_t lane_div(logic [15:0] num, logic [8:0] dvs);
    pcm_lane_t l;
    l.rem = num;
    l.dvs = dvs;
    l.quo = 8'd0;
    return l;
  endfunction

  function automatic logic [7:0] jet_level(logic [7:0] d);
    logic [7:0] t;
    t = 8'd0;
    if (d < JetRise) begin
      t = d + 8'd1;
      return {t[5:0], 2'b00};
    end else if (d < JetHoldEnd) begin
      return Full;
    end else if (d < JetFallEnd) begin
      t = d - JetFallBase;
      return Full - {t[5:0], 2'b00};
    end
    return 8'd0;
  endfunction

endpackage

@@ rtl/pcm_div_stage.sv @@
module pcm_div_stage import pcm_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic       advance_i,
  input  pcm_lanes_t lanes_i,
  output logic       valid_o,
  output pcm_lanes_t lanes_o
);

  localparam int TopBit = 7 - int'(BitsPerStep * STEP);

  pcm_lanes_t lanes_d;
  pcm_lanes_t lanes_q;
  logic       valid_q;

  always_comb begin
    logic [16:0] trial;
    trial   = 17'd0;
    lanes_d = lanes_i;
    for (int l = 0; l < NumLanes; l++) begin
      for (int j = 0; j < BitsPerStep; j++) begin
        trial = {8'd0, lanes_d[l].dvs} << (TopBit - j);
        if ({1'b0, lanes_d[l].rem} >= trial) begin
          lanes_d[l].rem              = lanes_d[l].rem - trial[15:0];
          lanes_d[l].quo[TopBit - j]  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

@@ rtl/pseudo_colour_mapper.sv @@
// Throughput: one item per cycle while out_stall_i is low; an input register, an operand
// and multiply stage, then four restoring divider stages of two quotient bits each.
// Stalls back up stage by stage, so empty stages still take items.
// Reset clears all valid bits and loads the register defaults (jet, full tints, spans 85).
module pseudo_colour_mapper import pcm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] intensity_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  localparam int unsigned NumStages = DivSteps + 2;

  logic [1:0] map_mode_q;
  logic [7:0] tint_red_q, tint_green_q, tint_blue_q;
  logic [7:0] red_span_q, green_span_q;

  logic              s1_valid_q, s2_valid_q;
  logic [7:0]        x_q;
  logic [DivSteps-1:0] div_valid;
  logic [NumStages-1:0] vld;
  logic [NumStages:0]   rdy;
  pcm_lanes_t        st_lanes [DivSteps+1];
  pcm_lanes_t        lanes_d;
  pcm_lanes_t        lanes_q;

  logic [7:0]  mul_a [NumLanes];
  logic [7:0]  mul_b [NumLanes];
  logic [15:0] prod  [NumLanes];
  logic [8:0]  split;
  logic [7:0]  jet_r, jet_g, jet_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_mode_q   <= MODE_JET;
      tint_red_q   <= 8'd255;
      tint_green_q <= 8'd255;
      tint_blue_q  <= 8'd255;
      red_span_q   <= 8'd85;
      green_span_q <= 8'd85;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAP_MODE:   map_mode_q   <= cfg_data_i[1:0];
        REG_TINT_RED:   tint_red_q   <= cfg_data_i;
        REG_TINT_GREEN: tint_green_q <= cfg_data_i;
        REG_TINT_BLUE:  tint_blue_q  <= cfg_data_i;
        REG_RED_SPAN:   red_span_q   <= cfg_data_i;
        REG_GREEN_SPAN: green_span_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign vld = {div_valid, s2_valid_q, s1_valid_q};
  assign rdy[NumStages] = !out_stall_i;
  for (genvar k = 0; k < NumStages; k++) begin : g_ready
    assign rdy[k] = !vld[k] || rdy[k+1];
  end
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (rdy[0]) begin
        s1_valid_q <= in_valid_i;
      end
      if (rdy[1]) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x_q <= intensity_i;
    end
    if (rdy[1]) begin
      lanes_q <= lanes_d;
    end
  end

  assign st_lanes[0] = lanes_q;

  assign split = {1'b0, red_span_q} + {1'b0, green_span_q};

  always_comb begin
    mul_a[LaneRed]   = x_q;
    mul_a[LaneGreen] = x_q;
    mul_a[LaneBlue]  = x_q;
    mul_b[LaneRed]   = tint_red_q;
    mul_b[LaneGreen] = tint_green_q;
    mul_b[LaneBlue]  = tint_blue_q;
    if (map_mode_q == MODE_TEMP) begin
      mul_a[LaneGreen] = x_q - red_span_q;
      mul_a[LaneBlue]  = x_q - split[7:0];
      for (int l = 0; l < NumLanes; l++) begin
        mul_b[l] = Full;
      end
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_mul
    assign prod[l] = {8'd0, mul_a[l]} * {8'd0, mul_b[l]};
  end

  assign jet_r = (x_q < JetRedFloor) ? 8'd0 : jet_level(x_q - JetRedOffset);
  assign jet_g = jet_level(x_q - JetGreenOffset);
  assign jet_b = (x_q >= JetBlueCeil) ? 8'd0 : jet_level(x_q - JetBlueOffset);

  always_comb begin
    lanes_d[LaneRed]   = lane_const(jet_r);
    lanes_d[LaneGreen] = lane_const(jet_g);
    lanes_d[LaneBlue]  = lane_const(jet_b);
    unique case (map_mode_q)
      MODE_CONST: begin
        for (int l = 0; l < NumLanes; l++) begin
          lanes_d[l] = lane_div(prod[l], FullDiv);
        end
      end
      MODE_TEMP: begin
        if (x_q < red_span_q) begin
          lanes_d[LaneRed]   = lane_div(prod[LaneRed], {1'b0, red_span_q});
          lanes_d[LaneGreen] = lane_const(8'd0);
          lanes_d[LaneBlue]  = lane_const(8'd0);
        end else if ({1'b0, x_q} < split) begin
          lanes_d[LaneRed]   = lane_const(Full);
          lanes_d[LaneGreen] = lane_div(prod[LaneGreen], {1'b0, green_span_q});
          lanes_d[LaneBlue]  = lane_const(8'd0);
        end else begin
          lanes_d[LaneRed]   = lane_const(Full);
          lanes_d[LaneGreen] = lane_const(Full);
          lanes_d[LaneBlue]  = lane_div(prod[LaneBlue], Levels - split);
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < DivSteps; g++) begin : g_div
    pcm_div_stage #(
      .STEP(g)
    ) u_div_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vld[g+1]),
      .advance_i (rdy[g+2]),
      .lanes_i   (st_lanes[g]),
      .valid_o   (div_valid[g]),
      .lanes_o   (st_lanes[g+1])
    );
  end

  assign out_valid_o = div_valid[DivSteps-1];
  assign red_o       = st_lanes[DivSteps][LaneRed].quo;
  assign green_o     = st_lanes[DivSteps][LaneGreen].quo;
  assign blue_o      = st_lanes[DivSteps][LaneBlue].quo;

  a_empty_output_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  a_free_output_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_division_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ({1'b0, st_lanes[DivSteps][LaneRed].rem} < {8'd0, st_lanes[DivSteps][LaneRed].dvs}) &&
      ({1'b0, st_lanes[DivSteps][LaneGreen].rem} < {8'd0, st_lanes[DivSteps][LaneGreen].dvs}) &&
      ({1'b0, st_lanes[DivSteps][LaneBlue].rem} < {8'd0, st_lanes[DivSteps][LaneBlue].dvs}))
    else $error("remainder not below divisor at output");

endmodule

@@ sim/pseudo_colour_mapper_test.sv @@
module pseudo_colour_mapper_test;
  import pcm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  localparam logic [2:0] RegSpareLo = 3'd6;
  localparam logic [2:0] RegSpareHi = 3'd7;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxReported = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic [7:0] intensity = '0;
  logic       out_stall = 1'b0;
  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  logic [1:0] cur_mode = MODE_JET;
  logic [7:0] cur_tint_red = 8'd255;
  logic [7:0] cur_tint_green = 8'd255;
  logic [7:0] cur_tint_blue = 8'd255;
  logic [7:0] cur_red_span = 8'd85;
  logic [7:0] cur_green_span = 8'd85;

  colour_t pending_colours[$];
  bit      idle_on = 1'b1;
  bit      stall_on = 1'b1;
  int      items_sent = 0;
  int      results_seen = 0;
  int      cfg_writes = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      stall_left = 0;

  pseudo_colour_mapper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .intensity_i (intensity),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] jet_ramp(logic [7:0] x, logic [7:0] offset);
    int d;
    d = (int'(x) - int'(offset)) & 255;
    if (d < 63) return 8'((d + 1) * 4);
    if (d < 128) return 8'd255;
    if (d < 191) return 8'(255 - (d - 127) * 4);
    return 8'd0;
  endfunction

  function automatic colour_t colour_for(logic [7:0] x);
    colour_t c;
    int xi;
    int rs;
    int gs;
    int split;
    xi = x;
    rs = cur_red_span;
    gs = cur_green_span;
    split = rs + gs;
    c = '0;
    if (cur_mode == MODE_CONST) begin
      c.red = 8'(xi * cur_tint_red / 255);
      c.green = 8'(xi * cur_tint_green / 255);
      c.blue = 8'(xi * cur_tint_blue / 255);
    end else if (cur_mode == MODE_TEMP) begin
      if (xi < rs) begin
        c.red = 8'(xi * 255 / rs);
      end else if (xi < split) begin
        c.red = 8'd255;
        c.green = 8'((xi - rs) * 255 / gs);
      end else begin
        c.red = 8'd255;
        c.green = 8'd255;
        c.blue = 8'((xi - split) * 255 / (256 - split));
      end
    end else begin
      c.red = jet_ramp(x, 8'd96);
      c.green = jet_ramp(x, 8'd32);
      c.blue = jet_ramp(x, 8'd224);
      if (x < 8'd64) c.red = 8'd0;
      if (x >= 8'd192) c.blue = 8'd0;
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 8'd0;
    if (r < 25) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_intensity();
    logic [7:0] split;
    split = cur_red_span + cur_green_span;
    if ($urandom_range(0, 99) < 70) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd255;
      2: return cur_red_span;
      3: return cur_red_span - 8'd1;
      4: return split;
      5: return split - 8'd1;
      6: return 8'd63;
      7: return 8'd64;
      8: return 8'd127;
      9: return 8'd128;
      10: return 8'd191;
      default: return 8'd192;
    endcase
  endfunction

  task automatic send_intensity(input logic [7:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    intensity <= x;
    do @(posedge clk_i); while (in_stall_o);
    pending_colours.push_back(colour_for(x));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_colours.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (index)
      REG_MAP_MODE:   cur_mode = data[1:0];
      REG_TINT_RED:   cur_tint_red = data;
      REG_TINT_GREEN: cur_tint_green = data;
      REG_TINT_BLUE:  cur_tint_blue = data;
      REG_RED_SPAN:   cur_red_span = data;
      REG_GREEN_SPAN: cur_green_span = data;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) :
                   $urandom_range(10, 40);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    colour_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (pending_colours.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("ERROR: unexpected result r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
      end else begin
        want = pending_colours.pop_front();
        if (want.red !== red_o || want.green !== green_o || want.blue !== blue_o) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("ERROR: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, red_o, green_o, blue_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("ERROR: no progress for %0d cycles", StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_jet_defaults();
    logic [7:0] edges[8] = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
    foreach (edges[i]) send_intensity(edges[i]);
    wait_drained();
  endtask

  task automatic test_constant_tint();
    write_reg(REG_MAP_MODE, 8'(MODE_CONST));
    write_reg(REG_TINT_RED, 8'd255);
    write_reg(REG_TINT_GREEN, 8'd0);
    write_reg(REG_TINT_BLUE, 8'd128);
    send_intensity(8'd0);
    send_intensity(8'd255);
    send_intensity(8'd200);
    wait_drained();
  endtask

  task automatic test_temperature_spans();
    write_reg(REG_MAP_MODE, 8'(MODE_TEMP));
    write_reg(REG_RED_SPAN, 8'd0);
    write_reg(REG_GREEN_SPAN, 8'd0);
    send_intensity(8'd0);
    send_intensity(8'd255);
    wait_drained();
    write_reg(REG_RED_SPAN, 8'd200);
    write_reg(REG_GREEN_SPAN, 8'd100);
    send_intensity(8'd199);
    send_intensity(8'd200);
    send_intensity(8'd255);
    wait_drained();
    write_reg(REG_RED_SPAN, 8'd255);
    write_reg(REG_GREEN_SPAN, 8'd0);
    send_intensity(8'd254);
    send_intensity(8'd255);
    wait_drained();
  endtask

  task automatic test_mode_decode();
    write_reg(REG_MAP_MODE, 8'd3);
    send_intensity(8'd100);
    wait_drained();
    write_reg(RegSpareLo, 8'd0);
    write_reg(RegSpareHi, 8'd255);
    write_reg(REG_MAP_MODE, 8'hFD);
    write_reg(REG_RED_SPAN, 8'd85);
    write_reg(REG_GREEN_SPAN, 8'd85);
    send_intensity(8'd170);
    send_intensity(8'd171);
    wait_drained();
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 10; phase++) begin
      idle_on = (phase % 3 != 0);
      stall_on = (phase % 4 != 1);
      write_reg(REG_MAP_MODE, {6'($urandom_range(0, 63)), 2'(phase % 4)});
      write_reg(REG_TINT_RED, pick_level());
      write_reg(REG_TINT_GREEN, pick_level());
      write_reg(REG_TINT_BLUE, pick_level());
      write_reg(REG_RED_SPAN, pick_level());
      write_reg(REG_GREEN_SPAN, pick_level());
      if ($urandom_range(0, 3) == 0)
        write_reg(3'($urandom_range(6, 7)), 8'($urandom_range(0, 255)));
      repeat (100) send_intensity(pick_intensity());
      wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_jet_defaults();
    test_constant_tint();
    test_temperature_spans();
    test_mode_decode();
    test_random_mix();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered: all map modes incl. unused code, span and tint extremes, spare indexes");
    $display("Sent %0d items, checked %0d colours, %0d register writes, %0d mismatches",
             items_sent, results_seen, cfg_writes, mismatches);
    if (mismatches == 0 && pending_colours.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ pseudo_colour_mapper.f @@
rtl/pcm_pkg.sv
rtl/pcm_div_stage.sv
rtl/pseudo_colour_mapper.sv
sim/pseudo_colour_mapper_test.sv
